// File: design/ddo_pkg.sv
// ============================================================================
// ddo_pkg
// Shared types, constants and a function of the wheel odometry block.
// ============================================================================
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic [31:0] CORDIC_X0 = 32'd652032874;

    localparam logic [1:0] REG_DIST_GAIN   = 2'd0;
    localparam logic [1:0] REG_YAW_GAIN    = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd2;

    localparam logic [23:0] DIST_GAIN_RST   = 24'd14641;
    localparam logic [23:0] YAW_GAIN_RST    = 24'd1988411;
    localparam logic [15:0] SAMPLE_RATE_RST = 16'd50;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_ROT1  = 7'b0001000,
        S_POS   = 7'b0010000,
        S_ROT2  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic rot_start;
        logic rot_half;
        logic rot_step;
        logic pos;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic rot_done;
    } t_status;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: design/diff_drive_odometry.sv
// ============================================================================
// diff_drive_odometry
// Differential drive wheel odometry with APB configuration registers.
// ============================================================================
// A request runs from acceptance to a valid result through two passes of the
// single iterative CORDIC unit: one for the new heading and one for the half
// heading. The next request is taken as soon as the result sits in the output
// register.
module diff_drive_odometry import ddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_count_left_front,
    input  logic signed [31:0] i_count_left_rear,
    input  logic signed [31:0] i_count_right_front,
    input  logic signed [31:0] i_count_right_rear,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [39:0] o_pos_x,
    output logic signed [39:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic signed [47:0] o_lin_vel,
    output logic signed [47:0] o_ang_vel,
    output logic signed [17:0] o_quat_z,
    output logic signed [17:0] o_quat_w
);

    logic [23:0] r_dist_gain, r_yaw_gain;
    logic [15:0] r_sample_rate;
    logic        r_out_valid;
    logic        out_free;
    t_cmd        cmd;
    t_status     status;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gain   <= DIST_GAIN_RST;
            r_yaw_gain    <= YAW_GAIN_RST;
            r_sample_rate <= SAMPLE_RATE_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_DIST_GAIN:   r_dist_gain   <= pwdata[23:0];
                REG_YAW_GAIN:    r_yaw_gain    <= pwdata[23:0];
                REG_SAMPLE_RATE: r_sample_rate <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DIST_GAIN:   prdata = {8'h0, r_dist_gain};
            REG_YAW_GAIN:    prdata = {8'h0, r_yaw_gain};
            REG_SAMPLE_RATE: prdata = {16'h0, r_sample_rate};
            default:         prdata = '0;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ddo_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_dist_gain         (r_dist_gain),
        .i_yaw_gain          (r_yaw_gain),
        .i_sample_rate       (r_sample_rate),
        .i_count_left_front  (i_count_left_front),
        .i_count_left_rear   (i_count_left_rear),
        .i_count_right_front (i_count_right_front),
        .i_count_right_rear  (i_count_right_rear),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_heading           (o_heading),
        .o_lin_vel           (o_lin_vel),
        .o_ang_vel           (o_ang_vel),
        .o_quat_z            (o_quat_z),
        .o_quat_w            (o_quat_w)
    );

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> out_free) else $error("result written over a pending one");
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_quat_w <= 18'sd65536 && o_quat_w >= -18'sd65536))
        else $error("quat_w out of range");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_in_stall) else $error("second request taken while busy");

endmodule

// File: design/ddo_ctrl.sv
// ============================================================================
// ddo_ctrl
// Sequencer that steps the datapath through one sample request.
// ============================================================================
module ddo_ctrl import ddo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.rot_start = 1'b1;
                n_state = S_ROT1;
            end
            S_ROT1: begin
                o_cmd.rot_step = 1'b1;
                if (i_status.rot_done) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                o_cmd.rot_start = 1'b1;
                o_cmd.rot_half = 1'b1;
                n_state = S_ROT2;
            end
            S_ROT2: begin
                o_cmd.rot_step = 1'b1;
                if (i_status.rot_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/ddo_cordic.sv
// ============================================================================
// ddo_cordic
// Iterative rotation-mode CORDIC giving Q1.16 cosine and sine of an angle.
// ============================================================================
module ddo_cordic import ddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_step,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [17:0] o_cos,
    output logic signed [17:0] o_sin
);

    logic signed [33:0] r_x, n_x, r_y, n_y;
    logic signed [32:0] r_z, n_z;
    logic               r_flip;
    logic [STEP_W-1:0]  r_cnt;
    logic signed [33:0] dx, dy;
    logic signed [32:0] ang_s, fold_s;
    logic signed [33:0] rc_w, rs_w;
    logic signed [17:0] rc, rs;

    assign ang_s  = 33'(signed'(i_angle));
    assign fold_s = 33'(signed'(i_angle + 32'h80000000));
    assign dx = r_y >>> r_cnt;
    assign dy = r_x >>> r_cnt;
    assign o_done = (r_cnt == STEP_W'(CORDIC_STEPS));

    always_comb begin
        if (r_z >= 0) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - 33'(signed'({1'b0, atan_lut(5'(r_cnt))}));
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + 33'(signed'({1'b0, atan_lut(5'(r_cnt))}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= STEP_W'(CORDIC_STEPS);
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= 34'(signed'({1'b0, CORDIC_X0}));
            r_y <= '0;
            if (ang_s > 33'sh040000000 || ang_s < -33'sh040000000) begin
                r_z <= fold_s;
                r_flip <= 1'b1;
            end else begin
                r_z <= ang_s;
                r_flip <= 1'b0;
            end
        end else if (i_step && !o_done) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_comb begin
        rc_w = (r_x + 34'sd8192) >>> 14;
        rs_w = (r_y + 34'sd8192) >>> 14;
        if (rc_w > 34'sd65536) rc = 18'sd65536;
        else if (rc_w < -34'sd65536) rc = -18'sd65536;
        else rc = 18'(rc_w);
        if (rs_w > 34'sd65536) rs = 18'sd65536;
        else if (rs_w < -34'sd65536) rs = -18'sd65536;
        else rs = 18'(rs_w);
        o_cos = r_flip ? -rc : rc;
        o_sin = r_flip ? -rs : rs;
    end

endmodule

// File: design/ddo_datapath.sv
// ============================================================================
// ddo_datapath
// Odometry arithmetic: deltas, gains, heading, position and velocities.
// ============================================================================
module ddo_datapath import ddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [23:0]        i_dist_gain,
    input  logic [23:0]        i_yaw_gain,
    input  logic [15:0]        i_sample_rate,
    input  logic signed [31:0] i_count_left_front,
    input  logic signed [31:0] i_count_left_rear,
    input  logic signed [31:0] i_count_right_front,
    input  logic signed [31:0] i_count_right_rear,
    output logic signed [39:0] o_pos_x,
    output logic signed [39:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic signed [47:0] o_lin_vel,
    output logic signed [47:0] o_ang_vel,
    output logic signed [17:0] o_quat_z,
    output logic signed [17:0] o_quat_w
);

    logic signed [31:0] r_prev_l, r_prev_r;
    logic signed [39:0] r_acc_x, r_acc_y;
    logic [31:0]        r_acc_h;
    logic signed [32:0] r_left, r_right;
    logic signed [22:0] r_sum, r_diff;
    logic signed [45:0] r_dist;
    logic signed [45:0] r_dyaw;
    logic signed [47:0] r_lin, r_ang;

    logic signed [32:0] lsum, rsum, ldiv, rdiv;
    logic signed [33:0] dl_w, dr_w;
    logic signed [21:0] dl, dr;
    logic signed [46:0] prod_d;
    logic signed [45:0] dist_n;
    logic signed [45:0] dyaw_n;
    logic [31:0]        head_n;
    logic               rot_start;
    logic [31:0]        rot_ang;
    logic               rot_done;
    logic signed [17:0] cs, sn;
    logic signed [64:0] px, py;
    logic signed [64:0] sx, sy;
    logic signed [39:0] ax, ay;
    logic signed [63:0] lv, av;

    function automatic logic signed [21:0] clampd(input logic signed [33:0] d);
        if (d > 34'sd1048576) return 22'sd1048576;
        if (d < -34'sd1048576) return -22'sd1048576;
        return 22'(d);
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [64:0] v);
        if (v > 65'sh7FFFFFFFFF) return 40'sh7FFFFFFFFF;
        if (v < -65'sh8000000000) return -40'sh8000000000;
        return 40'(v);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
        if (v < -64'sh800000000000) return -48'sh800000000000;
        return 48'(v);
    endfunction

    assign lsum = 33'(i_count_left_front) + 33'(i_count_left_rear);
    assign rsum = 33'(i_count_right_front) + 33'(i_count_right_rear);
    assign ldiv = (lsum + 33'(signed'({1'b0, lsum[32]}))) >>> 1;
    assign rdiv = (rsum + 33'(signed'({1'b0, rsum[32]}))) >>> 1;

    assign dl_w = 34'(r_left) - 34'(r_prev_l);
    assign dr_w = 34'(r_right) - 34'(r_prev_r);
    assign dl = clampd(dl_w);
    assign dr = clampd(dr_w);

    assign prod_d = 47'(r_sum) * 47'(signed'({1'b0, i_dist_gain}));
    assign dist_n = 46'((prod_d + 47'(signed'({1'b0, prod_d[46]}))) >>> 1);
    assign dyaw_n = 46'(r_diff) * 46'(signed'({1'b0, i_yaw_gain}));
    assign head_n = r_acc_h + 32'(dyaw_n);

    assign rot_ang = i_cmd.rot_half ? {r_acc_h[31], r_acc_h[31:1]} : head_n;
    assign rot_start = i_cmd.rot_start;

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_step  (i_cmd.rot_step),
        .i_angle (rot_ang),
        .o_done  (rot_done),
        .o_cos   (cs),
        .o_sin   (sn)
    );

    assign o_status.rot_done = rot_done;

    assign px = 65'(r_dist) * 65'(cs);
    assign py = 65'(r_dist) * 65'(sn);
    assign sx = 65'(r_acc_x) + ((px + 65'sd32768) >>> 16);
    assign sy = 65'(r_acc_y) + ((py + 65'sd32768) >>> 16);
    assign ax = sat40(sx);
    assign ay = sat40(sy);

    assign lv = 64'(r_dist) * 64'(signed'({1'b0, i_sample_rate}));
    assign av = 64'(r_dyaw) * 64'(signed'({1'b0, i_sample_rate}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_acc_h  <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_prev_l <= 32'(r_left);
                r_prev_r <= 32'(r_right);
            end
            if (i_cmd.mul) begin
                r_acc_h <= head_n;
            end
            if (i_cmd.pos) begin
                r_acc_x <= ax;
                r_acc_y <= ay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= ldiv;
            r_right <= rdiv;
        end
        if (i_cmd.prep) begin
            r_sum  <= 23'(dl) + 23'(dr);
            r_diff <= 23'(dr) - 23'(dl);
        end
        if (i_cmd.mul) begin
            r_dist <= dist_n;
            r_dyaw <= dyaw_n;
        end
        if (i_cmd.pos) begin
            r_lin <= sat48(lv);
            r_ang <= sat48(av);
        end
        if (i_cmd.fin) begin
            o_pos_x   <= r_acc_x;
            o_pos_y   <= r_acc_y;
            o_heading <= r_acc_h;
            o_lin_vel <= r_lin;
            o_ang_vel <= r_ang;
            o_quat_z  <= sn;
            o_quat_w  <= cs;
        end
    end

endmodule
